// ----- rtl/vfc_pkg.sv -----
// shared types and constants for the voxel face visibility cull unit
// no dependencies; imported by every module of the block
package vfc_pkg;

  // input field widths and tdata offsets, lowest field first
  localparam int POS_X_W      = 4;
  localparam int POS_Y_W      = 8;
  localparam int POS_Z_W      = 4;
  localparam int BTYPE_W      = 12;
  localparam int POS_X_LSB    = 0;
  localparam int POS_Y_LSB    = POS_X_LSB + POS_X_W;
  localparam int POS_Z_LSB    = POS_Y_LSB + POS_Y_W;
  localparam int BTYPE_LSB    = POS_Z_LSB + POS_Z_W;
  localparam int OPAQUE_BIT   = BTYPE_LSB + BTYPE_W;
  localparam int IN_TDATA_W   = 32;

  // result field widths
  localparam int FACE_W       = 6;
  localparam int CTYPE_W      = 12;
  localparam int OUT_FIELDS_W = FACE_W + CTYPE_W;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // command queue between front and back
  localparam int QUEUE_DEPTH  = 2;

  // tuser function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [FACE_W-1:0] FACE_ALL = '1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_QUERY_OUT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [POS_X_W-1:0]   x;
    logic [POS_Y_W-1:0]   y;
    logic [POS_Z_W-1:0]   z;
    logic [BTYPE_W-1:0]   btype;
    logic                 opaque;
  } cmd_t;

  // read order of a query: own cell then the six neighbors
  typedef enum logic [2:0] {
    STEP_SELF,
    STEP_UP,
    STEP_DOWN,
    STEP_EAST,
    STEP_WEST,
    STEP_SOUTH,
    STEP_NORTH
  } step_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_FINISH
  } bk_state_t;

  typedef struct packed {
    logic pop;
    logic emit;
  } bk_stat_t;

endpackage

// ----- rtl/vfc_front.sv -----
// front end: takes input items, bounds-checks them and turns them into commands
// depends on vfc_pkg
module vfc_front
  import vfc_pkg::*;
#(
  parameter int SIZE_X = 16,
  parameter int SIZE_Y = 256,
  parameter int SIZE_Z = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  q_full,
  output logic                  push,
  output cmd_t                  push_cmd
);

  logic in_chunk;
  logic drop;
  logic seen_r;

  always_comb begin
    push_cmd.x      = in_tdata[POS_X_LSB +: POS_X_W];
    push_cmd.y      = in_tdata[POS_Y_LSB +: POS_Y_W];
    push_cmd.z      = in_tdata[POS_Z_LSB +: POS_Z_W];
    push_cmd.btype  = in_tdata[BTYPE_LSB +: BTYPE_W];
    push_cmd.opaque = in_tdata[OPAQUE_BIT];
    in_chunk = (push_cmd.x < SIZE_X) && (push_cmd.y < SIZE_Y) && (push_cmd.z < SIZE_Z);
    drop     = 1'b0;
    if (in_tuser == FUNC_WRITE) begin
      push_cmd.kind = CMD_WRITE;
      drop          = !in_chunk;
    end else if (in_chunk) begin
      push_cmd.kind = CMD_QUERY;
    end else begin
      push_cmd.kind = CMD_QUERY_OUT;
    end
  end

  // hold off input until reset has been seen released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= 1'b1;
    end
  end

  assign in_tready = seen_r && !q_full;
  assign push      = in_tvalid && in_tready && !drop;

endmodule

// ----- rtl/vfc_queue.sv -----
// short command queue that decouples the front end from the store sequencer
// depends on vfc_pkg for the command type and depth
module vfc_queue
  import vfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic valid,
  output logic full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign valid = (cnt_r != '0);
  assign full  = (cnt_r == FULL_CNT);

endmodule

// ----- rtl/vfc_back.sv -----
// back end: cell store memory, query read sequencer and result register
// depends on vfc_pkg; commands come from vfc_queue
module vfc_back
  import vfc_pkg::*;
#(
  parameter int SIZE_X    = 16,
  parameter int SIZE_Y    = 256,
  parameter int SIZE_Z    = 16,
  parameter int TYPE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  cmd_t               head,
  output bk_stat_t           stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [FACE_W-1:0]  out_face_mask,
  output logic [CTYPE_W-1:0] out_cell_type
);

  localparam int CELL_COUNT = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CELL_W     = TYPE_BITS + 1;
  localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(SIZE_X);
  localparam logic [ADDR_W-1:0] STRIDE_Z = ADDR_W'(SIZE_X * SIZE_Y);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  bk_state_t state_r, state_nxt;
  step_t     step_r;
  logic [POS_X_W-1:0] x_r;
  logic [POS_Y_W-1:0] y_r;
  logic [POS_Z_W-1:0] z_r;

  logic [CELL_W-1:0]    rd_data_r;
  logic                 eval_valid_r;
  logic                 eval_in_r;
  step_t                eval_step_r;
  logic [TYPE_BITS-1:0] own_r;
  logic [FACE_W-1:0]    mask_r;

  logic                 out_valid_r;
  logic [FACE_W-1:0]    out_face_r;
  logic [CTYPE_W-1:0]   out_type_r;

  logic               slot_free;
  logic               idle;
  step_t              sel_step;
  logic [POS_X_W:0]   nx;
  logic [POS_Y_W:0]   ny;
  logic [POS_Z_W:0]   nz;
  logic               n_in;
  logic [ADDR_W-1:0]  addr;
  logic               wr_en;
  logic               rd_en;
  logic               start;
  logic               issue;
  logic               emit_out;
  logic               face_vis;
  logic [FACE_W-1:0]  dir_bit;
  logic [FACE_W-1:0]  mask_now;

  assign slot_free = !out_valid_r || out_tready;
  assign idle      = (state_r == BK_IDLE);
  assign sel_step  = idle ? STEP_SELF : step_r;

  // neighbor coordinate for the current read; only the moved axis can leave the chunk
  always_comb begin
    nx   = {1'b0, (idle ? head.x : x_r)};
    ny   = {1'b0, (idle ? head.y : y_r)};
    nz   = {1'b0, (idle ? head.z : z_r)};
    n_in = 1'b1;
    case (sel_step)
      STEP_UP: begin
        n_in = (ny + 1'b1) < SIZE_Y;
        ny   = ny + 1'b1;
      end
      STEP_DOWN: begin
        n_in = (ny != '0);
        ny   = ny - 1'b1;
      end
      STEP_EAST: begin
        n_in = (nx + 1'b1) < SIZE_X;
        nx   = nx + 1'b1;
      end
      STEP_WEST: begin
        n_in = (nx != '0);
        nx   = nx - 1'b1;
      end
      STEP_SOUTH: begin
        n_in = (nz + 1'b1) < SIZE_Z;
        nz   = nz + 1'b1;
      end
      STEP_NORTH: begin
        n_in = (nz != '0);
        nz   = nz - 1'b1;
      end
      default: begin
        n_in = 1'b1;
      end
    endcase
    addr = ADDR_W'(nx) + ADDR_W'(ny) * STRIDE_Y + ADDR_W'(nz) * STRIDE_Z;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head_valid && head.kind == CMD_QUERY) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        if (step_r == STEP_NORTH) begin
          state_nxt = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    stat.pop = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    start    = 1'b0;
    issue    = 1'b0;
    emit_out = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          case (head.kind)
            CMD_WRITE: begin
              stat.pop = 1'b1;
              wr_en    = 1'b1;
            end
            CMD_QUERY: begin
              stat.pop = 1'b1;
              rd_en    = 1'b1;
              start    = 1'b1;
              issue    = 1'b1;
            end
            CMD_QUERY_OUT: begin
              stat.pop = slot_free;
              emit_out = slot_free;
            end
            default: begin
              stat.pop = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        rd_en = n_in;
        issue = 1'b1;
      end
      BK_FINISH: begin
        emit_out = slot_free;
      end
      default: begin
        stat.pop = 1'b0;
      end
    endcase
    stat.emit = emit_out;
  end

  // single-port cell store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= {head.opaque, TYPE_BITS'(head.btype)};
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // evaluate the cell read in the previous cycle
  always_comb begin
    face_vis = !eval_in_r ||
               (!rd_data_r[TYPE_BITS] && (rd_data_r[TYPE_BITS-1:0] != own_r));
    case (eval_step_r)
      STEP_UP:    dir_bit = 6'b000001;
      STEP_DOWN:  dir_bit = 6'b000010;
      STEP_EAST:  dir_bit = 6'b000100;
      STEP_WEST:  dir_bit = 6'b001000;
      STEP_SOUTH: dir_bit = 6'b010000;
      STEP_NORTH: dir_bit = 6'b100000;
      default:    dir_bit = '0;
    endcase
    mask_now = mask_r | ((eval_valid_r && face_vis) ? dir_bit : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      eval_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      eval_valid_r <= issue;
      if (emit_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= head.x;
      y_r    <= head.y;
      z_r    <= head.z;
      step_r <= STEP_UP;
    end else if (state_r == BK_READ && step_r != STEP_NORTH) begin
      step_r <= step_t'(step_r + 3'd1);
    end
    eval_in_r   <= n_in;
    eval_step_r <= sel_step;
    if (eval_valid_r && eval_step_r == STEP_SELF) begin
      own_r <= rd_data_r[TYPE_BITS-1:0];
    end
    mask_r <= start ? '0 : mask_now;
    if (emit_out) begin
      if (idle) begin
        out_face_r <= FACE_ALL;
        out_type_r <= '0;
      end else begin
        out_face_r <= mask_now;
        out_type_r <= CTYPE_W'(own_r);
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_face_mask = out_face_r;
  assign out_cell_type = out_type_r;

endmodule

// ----- rtl/voxel_face_visibility_cull_unit.sv -----
// top level of the voxel face visibility cull unit: front end, command queue, back end
// depends on vfc_pkg, vfc_front, vfc_queue and vfc_back
// a query is written into the queue at acceptance and then run by the back end
// an in-chunk query holds the single store port for the own cell read at dispatch,
//   six neighbor steps and a finish state that waits for a free result slot
// a write is done at dispatch; an out-of-chunk query is answered at dispatch once
//   the result slot is free; a write outside the chunk is dropped at the front
// reset: synchronous active-low rst_n clears queue, sequencer and result valid;
//   the cell store is not cleared and holds unknown data until written
module voxel_face_visibility_cull_unit
  import vfc_pkg::*;
#(
  parameter int SIZE_X    = 16,
  parameter int SIZE_Y    = 256,
  parameter int SIZE_Z    = 16,
  parameter int TYPE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pos_x[3:0], pos_y[11:4], pos_z[15:12], block_type[27:16], block_opaque[28], zeros
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func: 0 write cell, 1 query face mask
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // face_mask[5:0], cell_type[17:6], zeros
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // front to queue
  logic push;
  cmd_t push_cmd;

  // queue to back
  cmd_t     q_head;
  logic     q_valid;
  logic     q_full;
  bk_stat_t bk_stat;

  // result fields
  logic [FACE_W-1:0]  face_mask;
  logic [CTYPE_W-1:0] cell_type;

  // classify and bounds-check incoming items
  vfc_front #(
    .SIZE_X (SIZE_X),
    .SIZE_Y (SIZE_Y),
    .SIZE_Z (SIZE_Z)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // lets input keep flowing while a query walks its neighbors
  vfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (bk_stat.pop),
    .head     (q_head),
    .valid    (q_valid),
    .full     (q_full)
  );

  // store, neighbor read sequencer and result register
  vfc_back #(
    .SIZE_X    (SIZE_X),
    .SIZE_Y    (SIZE_Y),
    .SIZE_Z    (SIZE_Z),
    .TYPE_BITS (TYPE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_valid),
    .head          (q_head),
    .stat          (bk_stat),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_face_mask (face_mask),
    .out_cell_type (cell_type)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, cell_type, face_mask};

  // back end only takes a command that the queue really holds
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> q_valid)
    else $error("back end popped an empty queue");

  // a new result never overwrites one still waiting downstream
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.emit |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while stalled");

  // a full queue must present a command
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> q_valid)
    else $error("queue full but head not valid");

  // no item enters while the queue is full and nothing is popped
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !bk_stat.pop) |=> !$past(push))
    else $error("command pushed into a full queue");

endmodule
